// ===== rtl/assert_macros.svh =====
// Assertion macros of the priority queue, used by its controller.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and codes of the strict-priority queue with ECN marking.
// No dependencies; the modules and the testbench refer to it by scoped names.
package spq_pkg;

    // Request types.
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ENQ   = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_DEQ   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Marking modes; the other codes mean no marking.
    localparam logic [1:0] MODE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_PORT  = 2'd2;

    // Register indexes (word address).
    localparam logic [2:0] REG_ACTIVE = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_MEAN   = 3'd2;
    localparam logic [2:0] REG_THRESH = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;

    // Register reset values.
    localparam logic [3:0]  RST_ACTIVE = 4'd8;
    localparam logic [15:0] RST_LIMIT  = 16'd1000;
    localparam logic [15:0] RST_MEAN   = 16'd1500;
    localparam logic [15:0] RST_THRESH = 16'd65;
    localparam logic [1:0]  RST_MODE   = 2'd0;

    typedef struct packed {
        logic [3:0]  active_classes;
        logic [15:0] limit_packets;
        logic [15:0] mean_packet_bytes;
        logic [15:0] mark_threshold_packets;
        logic [1:0]  marking_mode;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic calc;
        logic commit;
    } t_cmd;

    // One stored packet descriptor.
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] bytes;
        logic        ce;
    } t_desc;

endpackage

// ===== rtl/spq_req_if.sv =====
// Request channel of the priority queue: valid/ready handshake and request payload.
// Depends on nothing.
interface spq_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] packet_tag;
    logic [15:0] packet_bytes;
    logic [7:0]  priority_req;
    logic        ecn_capable;

    modport source (
        output valid, req_type, packet_tag, packet_bytes, priority_req, ecn_capable,
        input  ready
    );
    modport sink (
        input  valid, req_type, packet_tag, packet_bytes, priority_req, ecn_capable,
        output ready
    );
endinterface

// ===== rtl/spq_rsp_if.sv =====
// Result channel of the priority queue: valid/ready handshake and result payload.
// Depends on nothing.
interface spq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [15:0] out_bytes;
    logic [2:0]  out_class;
    logic        congestion_marked;

    modport source (
        output valid, status, out_tag, out_bytes, out_class, congestion_marked,
        input  ready
    );
    modport sink (
        input  valid, status, out_tag, out_bytes, out_class, congestion_marked,
        output ready
    );
endinterface

// ===== rtl/spq_regs.sv =====
// APB configuration registers of the priority queue.
// Depends on spq_pkg for the register codes, reset values and the t_cfg type.
module spq_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output spq_pkg::t_cfg       o_cfg
);

    spq_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Register write; addresses beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_classes         <= spq_pkg::RST_ACTIVE;
            r_cfg.limit_packets          <= spq_pkg::RST_LIMIT;
            r_cfg.mean_packet_bytes      <= spq_pkg::RST_MEAN;
            r_cfg.mark_threshold_packets <= spq_pkg::RST_THRESH;
            r_cfg.marking_mode           <= spq_pkg::RST_MODE;
        end else if (wr_en) begin
            case (reg_idx)
                spq_pkg::REG_ACTIVE: r_cfg.active_classes         <= pwdata[3:0];
                spq_pkg::REG_LIMIT:  r_cfg.limit_packets          <= pwdata[15:0];
                spq_pkg::REG_MEAN:   r_cfg.mean_packet_bytes      <= pwdata[15:0];
                spq_pkg::REG_THRESH: r_cfg.mark_threshold_packets <= pwdata[15:0];
                spq_pkg::REG_MODE:   r_cfg.marking_mode           <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            spq_pkg::REG_ACTIVE: prdata = {28'd0, r_cfg.active_classes};
            spq_pkg::REG_LIMIT:  prdata = {16'd0, r_cfg.limit_packets};
            spq_pkg::REG_MEAN:   prdata = {16'd0, r_cfg.mean_packet_bytes};
            spq_pkg::REG_THRESH: prdata = {16'd0, r_cfg.mark_threshold_packets};
            spq_pkg::REG_MODE:   prdata = {30'd0, r_cfg.marking_mode};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/spq_ctrl.sv =====
// Controller of the priority queue: sequences each request through a lookup
// and a commit step and owns the result valid flag. Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output spq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CALC   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]    r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic          slot_free;
    spq_pkg::t_cmd cmd;

    // The result register is free when empty or being emptied in this cycle.
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_COMMIT) && slot_free);
    assign o_out_valid = r_out_valid;

    assign cmd.accept = i_in_valid && o_in_ready;
    assign cmd.calc   = (r_state == S_CALC);
    assign cmd.commit = (r_state == S_COMMIT) && slot_free;
    assign o_cmd      = cmd;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd.accept) n_state = S_CALC;
            end
            S_CALC: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (slot_free) n_state = cmd.accept ? S_CALC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A commit fills the result register; a taken beat empties it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A committed request always shows its result in the next cycle.
    `SPQ_ASSERT_NEXT(a_commit_shows_result, cmd.commit, r_out_valid)
    // No request is taken while the lookup of the previous one is running.
    `SPQ_ASSERT_IMPL(a_calc_blocks_input, r_state == S_CALC, !o_in_ready)
    // An accepted request always enters the lookup step next.
    `SPQ_ASSERT_NEXT(a_accept_to_calc, cmd.accept, r_state == S_CALC)

endmodule

// ===== rtl/spq_dp.sv =====
// Datapath of the priority queue: class pointers, counters, byte totals, the
// descriptor memory and the result register. Depends on spq_pkg.
module spq_dp #(
    parameter int NUM_CLASSES = 8,
    parameter int CLASS_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_cmd i_cmd,
    input  spq_pkg::t_cfg i_cfg,
    input  logic          i_req_type,
    input  logic [15:0]   i_packet_tag,
    input  logic [15:0]   i_packet_bytes,
    input  logic [7:0]    i_priority_req,
    input  logic          i_ecn_capable,
    output logic [1:0]    o_status,
    output logic [15:0]   o_out_tag,
    output logic [15:0]   o_out_bytes,
    output logic [2:0]    o_out_class,
    output logic          o_congestion_marked
);

    localparam int CLW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int NW        = $clog2(NUM_CLASSES + 1);
    localparam int PW        = $clog2(CLASS_DEPTH);
    localparam int CNTW      = $clog2(CLASS_DEPTH + 1);
    localparam int AW        = CLW + PW;
    localparam int MEM_DEPTH = 2 ** AW;

    // Captured request.
    logic          r_req_type;
    logic [15:0]   r_tag;
    logic [15:0]   r_bytes;
    logic [7:0]    r_prio;
    logic          r_ecn;

    // Per-class state.
    logic [PW-1:0]   r_head   [NUM_CLASSES];
    logic [PW-1:0]   r_tail   [NUM_CLASSES];
    logic [CNTW-1:0] r_count  [NUM_CLASSES];
    logic [31:0]     r_cbytes [NUM_CLASSES];
    logic [31:0]     r_total;

    // Descriptor memory.
    spq_pkg::t_desc  mem [MEM_DEPTH];
    spq_pkg::t_desc  r_rd;

    // Lookup results.
    logic [CLW-1:0]  r_cls;
    logic [PW-1:0]   r_ptr;
    logic [CNTW-1:0] r_cnt;
    logic [31:0]     r_cb;
    logic [32:0]     r_cls_sum;
    logic [32:0]     r_tot_sum;
    logic            r_found;
    logic [31:0]     r_limit;
    logic [31:0]     r_thresh;

    // Result register.
    logic [1:0]      r_o_status;
    logic [15:0]     r_o_tag;
    logic [15:0]     r_o_bytes;
    logic [2:0]      r_o_class;
    logic            r_o_ce;

    logic [4:0]      act_ext;
    logic [NW-1:0]   used;
    logic [CLW-1:0]  cls_enq;
    logic [CLW-1:0]  deq_cls;
    logic            deq_found;
    logic [CLW-1:0]  sel_cls;
    logic            is_enq;
    logic            full;
    logic            drop;
    logic            ce;
    logic [PW-1:0]   ptr_next;
    logic [CLW+2:0]  cls_wide;

    assign is_enq = (r_req_type == spq_pkg::REQ_ENQ);

    // Number of classes in use, clamped to one through NUM_CLASSES.
    assign act_ext = {1'b0, i_cfg.active_classes};
    always_comb begin
        if (act_ext == 5'd0) begin
            used = NW'(1);
        end else if (int'(act_ext) > NUM_CLASSES) begin
            used = NW'(NUM_CLASSES);
        end else begin
            used = NW'(act_ext);
        end
    end

    // Enqueue class: the priority, limited to the last class in use.
    always_comb begin
        if (int'(r_prio) >= int'(used)) begin
            cls_enq = CLW'(used - NW'(1));
        end else begin
            cls_enq = CLW'(r_prio);
        end
    end

    // Dequeue class: the lowest-numbered non-empty class in use.
    always_comb begin
        deq_found = 1'b0;
        deq_cls   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ((c < int'(used)) && (r_count[c] != '0)) begin
                deq_found = 1'b1;
                deq_cls   = CLW'(c);
            end
        end
    end

    assign sel_cls = is_enq ? cls_enq : deq_cls;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_tag      <= i_packet_tag;
            r_bytes    <= i_packet_bytes;
            r_prio     <= i_priority_req;
            r_ecn      <= i_ecn_capable;
        end
    end

    // Lookup step: read the selected class state and form the limits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_cls     <= sel_cls;
            r_found   <= deq_found;
            r_ptr     <= is_enq ? r_tail[sel_cls] : r_head[sel_cls];
            r_cnt     <= r_count[sel_cls];
            r_cb      <= r_cbytes[sel_cls];
            r_cls_sum <= {1'b0, r_cbytes[sel_cls]} + 33'(r_bytes);
            r_tot_sum <= {1'b0, r_total} + 33'(r_bytes);
            r_limit   <= 32'(i_cfg.limit_packets) * 32'(i_cfg.mean_packet_bytes);
            r_thresh  <= 32'(i_cfg.mark_threshold_packets) * 32'(i_cfg.mean_packet_bytes);
        end
    end

    // Commit-step decisions.
    assign full     = (r_cnt == CNTW'(CLASS_DEPTH));
    assign drop     = (r_tot_sum > {1'b0, r_limit}) || full;
    assign ce       = r_ecn &&
                      (((i_cfg.marking_mode == spq_pkg::MODE_QUEUE) &&
                        (r_cls_sum > {1'b0, r_thresh})) ||
                       ((i_cfg.marking_mode == spq_pkg::MODE_PORT) &&
                        (r_tot_sum > {1'b0, r_thresh})));
    assign ptr_next = (r_ptr == PW'(CLASS_DEPTH - 1)) ? '0 : r_ptr + PW'(1);
    assign cls_wide = {3'd0, r_cls};

    // Descriptor memory: head read in the lookup step, append in the commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_rd <= mem[{sel_cls, r_head[sel_cls]}];
        end
        if (i_cmd.commit && is_enq && !drop) begin
            mem[{r_cls, r_ptr}] <= '{tag: r_tag, bytes: r_bytes, ce: ce};
        end
    end

    // Class pointers, counters and byte totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]   <= '0;
                r_tail[c]   <= '0;
                r_count[c]  <= '0;
                r_cbytes[c] <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.commit) begin
            if (is_enq) begin
                if (!drop) begin
                    r_tail[r_cls]   <= ptr_next;
                    r_count[r_cls]  <= r_cnt + CNTW'(1);
                    r_cbytes[r_cls] <= r_cls_sum[31:0];
                    r_total         <= r_tot_sum[31:0];
                end
            end else if (r_found) begin
                r_head[r_cls]   <= ptr_next;
                r_count[r_cls]  <= r_cnt - CNTW'(1);
                r_cbytes[r_cls] <= r_cb - 32'(r_rd.bytes);
                r_total         <= r_total - 32'(r_rd.bytes);
            end
        end
    end

    // Result register, loaded when the request commits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (is_enq) begin
                r_o_status <= drop ? spq_pkg::ST_DROP : spq_pkg::ST_ENQ;
                r_o_tag    <= r_tag;
                r_o_bytes  <= r_bytes;
                r_o_class  <= cls_wide[2:0];
                r_o_ce     <= ce && !drop;
            end else if (r_found) begin
                r_o_status <= spq_pkg::ST_DEQ;
                r_o_tag    <= r_rd.tag;
                r_o_bytes  <= r_rd.bytes;
                r_o_class  <= cls_wide[2:0];
                r_o_ce     <= r_rd.ce;
            end else begin
                r_o_status <= spq_pkg::ST_EMPTY;
                r_o_tag    <= '0;
                r_o_bytes  <= '0;
                r_o_class  <= '0;
                r_o_ce     <= 1'b0;
            end
        end
    end

    assign o_status            = r_o_status;
    assign o_out_tag           = r_o_tag;
    assign o_out_bytes         = r_o_bytes;
    assign o_out_class         = r_o_class;
    assign o_congestion_marked = r_o_ce;

endmodule

// ===== rtl/strict_priority_queue_ecn.sv =====
// Top level of the strict-priority output queue with ECN marking.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_regs, spq_ctrl and spq_dp.
//
//   Port      Kind       Beat contents
//   i_req     sink       req_type, packet_tag, packet_bytes, priority_req, ecn_capable
//   o_rsp     source     status, out_tag, out_bytes, out_class, congestion_marked
//   APB       slave      five configuration registers at byte addresses 0 to 16
//
// After acceptance each request passes through a lookup step that reads the class
// counters, pointers and the descriptor memory port, and a commit step that writes
// them back. A new request can be taken while the last one commits, not in its lookup.
// Reset is synchronous and active low; the descriptor memory is not cleared.
// A result waiting on o_rsp does not stop the next request from being taken,
// but that request's commit waits until the waiting result has been taken.
module strict_priority_queue_ecn #(
    parameter int NUM_CLASSES = 8,
    parameter int CLASS_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_req_if.sink     i_req,
    spq_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    spq_pkg::t_cfg cfg;
    spq_pkg::t_cmd cmd;
    logic          in_ready;
    logic          out_valid;

    // Configuration registers.
    spq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Request sequencing.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // Queue state and result payload.
    spq_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg               (cfg),
        .i_req_type          (i_req.req_type),
        .i_packet_tag        (i_req.packet_tag),
        .i_packet_bytes      (i_req.packet_bytes),
        .i_priority_req      (i_req.priority_req),
        .i_ecn_capable       (i_req.ecn_capable),
        .o_status            (o_rsp.status),
        .o_out_tag           (o_rsp.out_tag),
        .o_out_bytes         (o_rsp.out_bytes),
        .o_out_class         (o_rsp.out_class),
        .o_congestion_marked (o_rsp.congestion_marked)
    );

endmodule

// ===== verif/strict_priority_queue_ecn_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the strict-priority output queue with ECN marking.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and strict_priority_queue_ecn from rtl.
module strict_priority_queue_ecn_tb;

    localparam int NUM_CLASSES = 8;
    localparam int CLASS_DEPTH = 256;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        req_type;
        logic [15:0] tag;
        logic [15:0] bytes;
        logic [7:0]  prio;
        logic        ecn;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] tag;
        logic [15:0] bytes;
        logic [2:0]  cls;
        logic        ce;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spq_req_if req_bus ();
    spq_rsp_if rsp_bus ();

    strict_priority_queue_ecn #(
        .NUM_CLASSES (NUM_CLASSES),
        .CLASS_DEPTH (CLASS_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Requests waiting to be driven, and outcomes waiting to be seen.
    t_request request_backlog[$];
    t_outcome awaited_outcomes[$];
    int       issued_count;
    int       checked_count;
    int       error_count;
    int       cycle_count;
    int       sender_idle_pct;
    int       receiver_stall_pct;

    // Mirror of the port: configuration, descriptor FIFOs and byte counters.
    spq_pkg::t_cfg   port_cfg;
    spq_pkg::t_desc  desc_mem [NUM_CLASSES][CLASS_DEPTH];
    int              fifo_head [NUM_CLASSES];
    int              fifo_level [NUM_CLASSES];
    longint unsigned class_level_bytes [NUM_CLASSES];
    longint unsigned port_level_bytes;

    // Works out the outcome of one request and updates the mirror to match.
    function automatic t_outcome queue_port_outcome(input t_request r);
        t_outcome        res;
        int              n;
        int              cls;
        int              slot;
        longint unsigned cap;
        longint unsigned mark_level;
        spq_pkg::t_desc  d;
        res = '0;
        n = port_cfg.active_classes;
        if (n > NUM_CLASSES) n = NUM_CLASSES;
        if (n < 1) n = 1;
        if (r.req_type == spq_pkg::REQ_ENQ) begin
            cls = (int'(r.prio) >= n) ? n - 1 : int'(r.prio);
            cap = port_cfg.limit_packets;
            cap = cap * port_cfg.mean_packet_bytes;
            mark_level = port_cfg.mark_threshold_packets;
            mark_level = mark_level * port_cfg.mean_packet_bytes;
            res.tag = r.tag;
            res.bytes = r.bytes;
            res.cls = 3'(cls);
            if (port_level_bytes + r.bytes > cap || fifo_level[cls] >= CLASS_DEPTH) begin
                res.status = spq_pkg::ST_DROP;
            end else begin
                class_level_bytes[cls] += r.bytes;
                port_level_bytes += r.bytes;
                res.status = spq_pkg::ST_ENQ;
                res.ce = r.ecn &&
                    ((port_cfg.marking_mode == spq_pkg::MODE_QUEUE &&
                      class_level_bytes[cls] > mark_level) ||
                     (port_cfg.marking_mode == spq_pkg::MODE_PORT &&
                      port_level_bytes > mark_level));
                slot = (fifo_head[cls] + fifo_level[cls]) % CLASS_DEPTH;
                desc_mem[cls][slot] = '{tag: r.tag, bytes: r.bytes, ce: res.ce};
                fifo_level[cls]++;
            end
        end else begin
            res.status = spq_pkg::ST_EMPTY;
            // Strict priority: the lowest-numbered active class with a packet wins.
            for (int c = 0; c < n; c++) begin
                if (res.status == spq_pkg::ST_EMPTY && fifo_level[c] > 0) begin
                    d = desc_mem[c][fifo_head[c]];
                    fifo_head[c] = (fifo_head[c] + 1) % CLASS_DEPTH;
                    fifo_level[c]--;
                    class_level_bytes[c] -= d.bytes;
                    port_level_bytes -= d.bytes;
                    res = '{status: spq_pkg::ST_DEQ, tag: d.tag, bytes: d.bytes,
                            cls: 3'(c), ce: d.ce};
                end
            end
        end
        return res;
    endfunction

    function automatic t_request enq_beat(input logic [15:0] tag, input logic [15:0] bytes,
                                          input logic [7:0] prio, input logic ecn);
        t_request r;
        r.req_type = spq_pkg::REQ_ENQ;
        r.tag = tag;
        r.bytes = bytes;
        r.prio = prio;
        r.ecn = ecn;
        return r;
    endfunction

    function automatic t_request deq_beat();
        t_request r;
        r = '0;
        r.req_type = spq_pkg::REQ_DEQ;
        return r;
    endfunction

    // Random request: mostly small sizes and low priorities, with the extremes mixed in.
    function automatic t_request random_request(input int enq_pct);
        t_request r;
        r.req_type = ($urandom_range(99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
        r.tag = 16'($urandom);
        case ($urandom_range(9))
            0:       r.bytes = 16'hFFFF;
            1:       r.bytes = 16'($urandom);
            default: r.bytes = 16'($urandom_range(1, 3000));
        endcase
        r.prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        r.ecn = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic push_request(input t_request r);
        request_backlog.push_back(r);
        issued_count++;
    endtask

    task automatic push_random(input int count, input int enq_pct);
        for (int k = 0; k < count; k++) push_request(random_request(enq_pct));
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        sender_idle_pct = send_pct;
        receiver_stall_pct = recv_pct;
    endtask

    // Holds off until every issued request has its outcome checked, then lets the
    // commit of the last request settle.
    task automatic wait_quiet();
        while (checked_count != issued_count) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            spq_pkg::REG_ACTIVE: port_cfg.active_classes = value[3:0];
            spq_pkg::REG_LIMIT:  port_cfg.limit_packets = value[15:0];
            spq_pkg::REG_MEAN:   port_cfg.mean_packet_bytes = value[15:0];
            spq_pkg::REG_THRESH: port_cfg.mark_threshold_packets = value[15:0];
            spq_pkg::REG_MODE:   port_cfg.marking_mode = value[1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [3:0] active, input logic [15:0] limit,
                                  input logic [15:0] mean, input logic [15:0] thresh,
                                  input logic [1:0] mode);
        write_register(spq_pkg::REG_ACTIVE, 32'(active));
        write_register(spq_pkg::REG_LIMIT, 32'(limit));
        write_register(spq_pkg::REG_MEAN, 32'(mean));
        write_register(spq_pkg::REG_THRESH, 32'(thresh));
        write_register(spq_pkg::REG_MODE, 32'(mode));
    endtask

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Request driver: one beat at a time from the backlog, with random gaps.
    always @(posedge i_clk) begin : drive_requests
        t_request beat_on_bus;
        logic     launch;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            launch = !req_bus.valid;
            if (req_bus.valid && req_bus.ready) begin
                awaited_outcomes.push_back(queue_port_outcome(beat_on_bus));
                launch = 1'b1;
            end
            if (launch) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    beat_on_bus = request_backlog.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.req_type <= beat_on_bus.req_type;
                    req_bus.packet_tag <= beat_on_bus.tag;
                    req_bus.packet_bytes <= beat_on_bus.bytes;
                    req_bus.priority_req <= beat_on_bus.prio;
                    req_bus.ecn_capable <= beat_on_bus.ecn;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result back-pressure.
    always @(posedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Result monitor: each accepted beat against the oldest outstanding outcome.
    always @(posedge i_clk) begin : check_outcomes
        t_outcome want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result beat with no request outstanding: status %0d tag %h",
                       rsp_bus.status, rsp_bus.out_tag);
                error_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, rsp_bus.status);
                    error_count++;
                end
                if (rsp_bus.out_tag !== want.tag) begin
                    $error("out_tag mismatch: expected %h, got %h", want.tag, rsp_bus.out_tag);
                    error_count++;
                end
                if (rsp_bus.out_bytes !== want.bytes) begin
                    $error("out_bytes mismatch: expected %0d, got %0d",
                           want.bytes, rsp_bus.out_bytes);
                    error_count++;
                end
                if (rsp_bus.out_class !== want.cls) begin
                    $error("out_class mismatch: expected %0d, got %0d", want.cls, rsp_bus.out_class);
                    error_count++;
                end
                if (rsp_bus.congestion_marked !== want.ce) begin
                    $error("congestion_marked mismatch: expected %b, got %b",
                           want.ce, rsp_bus.congestion_marked);
                    error_count++;
                end
                checked_count++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[strict_priority_queue_ecn] ERROR");
            $finish;
        end
    end

    // Stimulus: directed cases first, then random phases under several settings.
    initial begin : stimulus
        int fill_n;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.req_type = spq_pkg::REQ_ENQ;
        req_bus.packet_tag = '0;
        req_bus.packet_bytes = '0;
        req_bus.priority_req = '0;
        req_bus.ecn_capable = 1'b0;
        rsp_bus.ready = 1'b0;
        issued_count = 0;
        checked_count = 0;
        error_count = 0;
        cycle_count = 0;
        port_level_bytes = 0;
        port_cfg = '{active_classes: spq_pkg::RST_ACTIVE, limit_packets: spq_pkg::RST_LIMIT,
                     mean_packet_bytes: spq_pkg::RST_MEAN,
                     mark_threshold_packets: spq_pkg::RST_THRESH,
                     marking_mode: spq_pkg::RST_MODE};
        for (int c = 0; c < NUM_CLASSES; c++) begin
            fifo_head[c] = 0;
            fifo_level[c] = 0;
            class_level_bytes[c] = 0;
        end
        set_idling(20, 57);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Three classes, a 2000-byte buffer and per-queue marking above 100 bytes.
        apply_settings(4'd3, 16'd20, 16'd100, 16'd1, spq_pkg::MODE_QUEUE);
        push_request(deq_beat());                                  // empty port
        push_request(enq_beat(16'hFFFF, 16'hFFFF, 8'd0, 1'b1));    // over the byte limit
        push_request(enq_beat(16'h0000, 16'd150, 8'hFF, 1'b1));    // clamped to class 2, marked
        push_request(enq_beat(16'h0001, 16'd50, 8'd1, 1'b1));      // under the threshold
        push_request(enq_beat(16'h0002, 16'd0, 8'd1, 1'b0));       // zero-byte packet
        push_request(enq_beat(16'h1234, 16'd1, 8'd0, 1'b0));
        push_request(enq_beat(16'h5555, 16'd1800, 8'd0, 1'b1));    // dropped, so never marked
        repeat (5) push_request(deq_beat());                       // strict order, then empty
        push_request(enq_beat(16'hAAAA, 16'd100, 8'd2, 1'b1));
        wait_quiet();

        // One active class: the packet left in class 2 becomes invisible.
        write_register(spq_pkg::REG_ACTIVE, 32'd1);
        write_register(spq_pkg::REG_MODE, 32'(spq_pkg::MODE_PORT));
        push_request(deq_beat());
        push_request(enq_beat(16'hBBBB, 16'd60, 8'd7, 1'b1));
        push_request(deq_beat());
        push_request(deq_beat());
        wait_quiet();

        // Active count above the class count clamps to all classes.
        write_register(spq_pkg::REG_ACTIVE, 32'd15);
        push_request(deq_beat());
        push_request(deq_beat());
        wait_quiet();

        apply_settings(4'd8, 16'd40, 16'd1500, 16'd10, spq_pkg::MODE_QUEUE);
        push_random(50, 60);
        wait_quiet();

        apply_settings(4'd4, 16'd50, 16'd1000, 16'd3, spq_pkg::MODE_PORT);
        push_random(50, 65);
        wait_quiet();

        // A zero buffer limit drops every enqueue but zero-byte packets into an empty buffer.
        set_idling(57, 20);
        apply_settings(4'd0, 16'd0, 16'hFFFF, 16'hFFFF, 2'd0);
        push_random(20, 50);
        wait_quiet();

        // Fill class 0 to its depth and past it, then drain part of it.
        apply_settings(4'd1, 16'hFFFF, 16'hFFFF, 16'd0, spq_pkg::MODE_QUEUE);
        fill_n = CLASS_DEPTH - fifo_level[0] + 6;
        push_random(fill_n, 100);
        push_random(100, 0);
        wait_quiet();

        // The unused marking code must not mark even with a zero threshold.
        set_idling(0, 0);
        apply_settings(4'd9, 16'hFFFF, 16'hFFFF, 16'd0, 2'd3);
        push_random(50, 55);
        wait_quiet();

        apply_settings(4'($urandom_range(0, 15)), 16'($urandom_range(20, 200)),
                       16'($urandom_range(1, 65535)), 16'($urandom), 2'($urandom_range(0, 3)));
        push_random(50, 55);
        wait_quiet();

        if (error_count == 0) begin
            $display("[strict_priority_queue_ecn] OK");
        end else begin
            $display("[strict_priority_queue_ecn] ERROR");
        end
        $finish;
    end

endmodule

// ===== strict_priority_queue_ecn.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_regs.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/strict_priority_queue_ecn.sv
verif/strict_priority_queue_ecn_tb.sv
